// ===== rtl/core/kts_pkg.sv =====
// shared constants, types, lfsr step and control store for the rank selector
package kts_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int VAL_W        = 32;
   localparam int RANK_W       = 7;
   localparam int RND_W        = 16;
   localparam int PROD_W       = RND_W + CNT_W;
   localparam int UPC_W        = 5;

   localparam logic [RND_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [RND_W-1:0] LFSR_TAPS = 16'hB400;

   // memory read address select
   typedef enum logic [2:0] {
      RD_NONE = 3'd0,
      RD_PICK = 3'd1,
      RD_HI   = 3'd2,
      RD_J    = 3'd3,
      RD_ST   = 3'd4,
      RD_LO   = 3'd5
   } rd_type;

   // memory write address and data select
   typedef enum logic [2:0] {
      WR_NONE    = 3'd0,
      WR_PICK_RD = 3'd1,
      WR_HI_A    = 3'd2,
      WR_ST_A    = 3'd3,
      WR_J_B     = 3'd4,
      WR_ST_PV   = 3'd5
   } wr_type;

   // register actions
   typedef enum logic [3:0] {
      ACT_NONE     = 4'd0,
      ACT_RAND     = 4'd1,
      ACT_PICK     = 4'd2,
      ACT_A        = 4'd3,
      ACT_PV_INIT  = 4'd4,
      ACT_B        = 4'd5,
      ACT_ADV      = 4'd6,
      ACT_JINC     = 4'd7,
      ACT_NARROW   = 4'd8,
      ACT_DONE_PV  = 4'd9,
      ACT_DONE_RD  = 4'd10,
      ACT_DONE_ERR = 4'd11
   } act_type;

   // jump conditions
   typedef enum logic [2:0] {
      JC_NONE      = 3'd0,
      JC_ALWAYS    = 3'd1,
      JC_ERR       = 3'd2,
      JC_LO_GE_HI  = 3'd3,
      JC_J_EQ_HI   = 3'd4,
      JC_GT_PV     = 3'd5,
      JC_WANT_EQ_K = 3'd6
   } jc_type;

   typedef struct packed {
      rd_type           rd;
      wr_type           wr;
      act_type          act;
      jc_type           jc;
      logic [UPC_W-1:0] jt;
      logic             fin;
   } uword_type;

   typedef struct packed {
      logic err;
      logic lo_ge_hi;
      logic j_eq_hi;
      logic gt_pv;
      logic want_eq_k;
   } flags_type;

   typedef struct packed {
      logic busy;
      logic finish;
   } seq_stat_type;

   typedef struct packed {
      logic                    we;
      logic [IDX_W-1:0]        addr;
      logic signed [VAL_W-1:0] data;
   } load_type;

   typedef struct packed {
      logic              go;
      logic [CNT_W-1:0]  count;
      logic [RANK_W-1:0] rank;
   } start_type;

   // step addresses
   localparam logic [UPC_W-1:0] U_CHK     = 5'd0;
   localparam logic [UPC_W-1:0] U_TEST    = 5'd1;
   localparam logic [UPC_W-1:0] U_RAND    = 5'd2;
   localparam logic [UPC_W-1:0] U_PICK    = 5'd3;
   localparam logic [UPC_W-1:0] U_SWP_HI  = 5'd4;
   localparam logic [UPC_W-1:0] U_SWP_W1  = 5'd5;
   localparam logic [UPC_W-1:0] U_SWP_W2  = 5'd6;
   localparam logic [UPC_W-1:0] U_L0      = 5'd7;
   localparam logic [UPC_W-1:0] U_L1      = 5'd8;
   localparam logic [UPC_W-1:0] U_L2      = 5'd9;
   localparam logic [UPC_W-1:0] U_L3      = 5'd10;
   localparam logic [UPC_W-1:0] U_SKIP    = 5'd11;
   localparam logic [UPC_W-1:0] U_E0      = 5'd12;
   localparam logic [UPC_W-1:0] U_E1      = 5'd13;
   localparam logic [UPC_W-1:0] U_E2      = 5'd14;
   localparam logic [UPC_W-1:0] U_NARROW  = 5'd15;
   localparam logic [UPC_W-1:0] U_HIT     = 5'd16;
   localparam logic [UPC_W-1:0] U_FIN     = 5'd17;
   localparam logic [UPC_W-1:0] U_FIN2    = 5'd18;
   localparam logic [UPC_W-1:0] U_ERR     = 5'd19;

   function automatic logic [RND_W-1:0] lfsr_step(input logic [RND_W-1:0] s);
      logic [RND_W-1:0] t;
      t = s >> 1;
      if (s[0]) t = t ^ LFSR_TAPS;
      if (t == '0) t = LFSR_SEED;
      return t;
   endfunction

   function automatic uword_type mk_word(input rd_type rd, input wr_type wr,
                                         input act_type act, input jc_type jc,
                                         input logic [UPC_W-1:0] jt, input logic fin);
      uword_type w;
      w.rd  = rd;
      w.wr  = wr;
      w.act = act;
      w.jc  = jc;
      w.jt  = jt;
      w.fin = fin;
      return w;
   endfunction

   localparam uword_type UW_NOP = '{rd: RD_NONE, wr: WR_NONE, act: ACT_NONE,
                                    jc: JC_NONE, jt: U_CHK, fin: 1'b0};

   // control store
   function automatic uword_type ucode(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = UW_NOP;
      unique case (upc)
         U_CHK:    w = mk_word(RD_NONE, WR_NONE,    ACT_NONE,     JC_ERR,       U_ERR,   1'b0);
         U_TEST:   w = mk_word(RD_NONE, WR_NONE,    ACT_NONE,     JC_LO_GE_HI,  U_FIN,   1'b0);
         U_RAND:   w = mk_word(RD_NONE, WR_NONE,    ACT_RAND,     JC_NONE,      U_CHK,   1'b0);
         U_PICK:   w = mk_word(RD_PICK, WR_NONE,    ACT_PICK,     JC_NONE,      U_CHK,   1'b0);
         U_SWP_HI: w = mk_word(RD_HI,   WR_NONE,    ACT_A,        JC_NONE,      U_CHK,   1'b0);
         U_SWP_W1: w = mk_word(RD_NONE, WR_PICK_RD, ACT_NONE,     JC_NONE,      U_CHK,   1'b0);
         U_SWP_W2: w = mk_word(RD_NONE, WR_HI_A,    ACT_PV_INIT,  JC_NONE,      U_CHK,   1'b0);
         U_L0:     w = mk_word(RD_J,    WR_NONE,    ACT_NONE,     JC_J_EQ_HI,   U_E0,    1'b0);
         U_L1:     w = mk_word(RD_ST,   WR_NONE,    ACT_A,        JC_GT_PV,     U_SKIP,  1'b0);
         U_L2:     w = mk_word(RD_NONE, WR_ST_A,    ACT_B,        JC_NONE,      U_CHK,   1'b0);
         U_L3:     w = mk_word(RD_NONE, WR_J_B,     ACT_ADV,      JC_ALWAYS,    U_L0,    1'b0);
         U_SKIP:   w = mk_word(RD_NONE, WR_NONE,    ACT_JINC,     JC_ALWAYS,    U_L0,    1'b0);
         U_E0:     w = mk_word(RD_ST,   WR_NONE,    ACT_NONE,     JC_NONE,      U_CHK,   1'b0);
         U_E1:     w = mk_word(RD_NONE, WR_ST_PV,   ACT_A,        JC_NONE,      U_CHK,   1'b0);
         U_E2:     w = mk_word(RD_NONE, WR_HI_A,    ACT_NONE,     JC_WANT_EQ_K, U_HIT,   1'b0);
         U_NARROW: w = mk_word(RD_NONE, WR_NONE,    ACT_NARROW,   JC_ALWAYS,    U_TEST,  1'b0);
         U_HIT:    w = mk_word(RD_NONE, WR_NONE,    ACT_DONE_PV,  JC_NONE,      U_CHK,   1'b1);
         U_FIN:    w = mk_word(RD_LO,   WR_NONE,    ACT_NONE,     JC_NONE,      U_CHK,   1'b0);
         U_FIN2:   w = mk_word(RD_NONE, WR_NONE,    ACT_DONE_RD,  JC_NONE,      U_CHK,   1'b1);
         U_ERR:    w = mk_word(RD_NONE, WR_NONE,    ACT_DONE_ERR, JC_NONE,      U_CHK,   1'b1);
         default:  w = mk_word(RD_NONE, WR_NONE,    ACT_DONE_ERR, JC_NONE,      U_CHK,   1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/kts_if.sv =====
// request and response channel interfaces of the rank selector
interface kts_req_if;
   import kts_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  value;
   logic [RANK_W-1:0]        rank;
   logic                     last;

   modport source (output valid, value, rank, last, input ready);
   modport sink   (input valid, value, rank, last, output ready);
endinterface

interface kts_rsp_if;
   import kts_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  selected;
   logic                     rank_error;

   modport source (output valid, selected, rank_error, input ready);
   modport sink   (input valid, selected, rank_error, output ready);
endinterface

// ===== rtl/core/kts_sequencer.sv =====
// step counter, control store lookup and conditional jumps
module kts_sequencer
   import kts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         stall,
   input  flags_type    flags,
   output uword_type    cw,
   output logic         hold,
   output seq_stat_type stat
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             busy_ff, busy_in;
   uword_type        word;
   logic             take;

   assign word = busy_ff ? ucode(upc_ff) : UW_NOP;
   assign cw   = word;
   assign hold = busy_ff && word.fin && stall;

   always_comb begin
      unique case (word.jc)
         JC_NONE:      take = 1'b0;
         JC_ALWAYS:    take = 1'b1;
         JC_ERR:       take = flags.err;
         JC_LO_GE_HI:  take = flags.lo_ge_hi;
         JC_J_EQ_HI:   take = flags.j_eq_hi;
         JC_GT_PV:     take = flags.gt_pv;
         JC_WANT_EQ_K: take = flags.want_eq_k;
         default:      take = 1'b0;
      endcase
   end

   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (start) begin
         upc_in  = U_CHK;
         busy_in = 1'b1;
      end else if (busy_ff && !hold) begin
         upc_in = take ? word.jt : upc_ff + UPC_W'(1);
         if (word.fin) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= U_CHK;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
      end
   end

   assign stat.busy   = busy_ff;
   assign stat.finish = busy_ff && word.fin && !hold;

endmodule

// ===== rtl/core/kts_datapath.sv =====
// element store, partition registers, pivot source and result mux
module kts_datapath
   import kts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  load_type                load,
   input  start_type               start,
   input  uword_type               cw,
   input  logic                    hold,
   output flags_type               flags,
   output logic signed [VAL_W-1:0] res_value,
   output logic                    res_err
);

   logic signed [VAL_W-1:0] store_mem [MAX_ELEMENTS];

   logic [IDX_W-1:0]        lo_ff, hi_ff, j_ff, st_ff, pick_ff;
   logic [CNT_W-1:0]        want_ff;
   logic                    err_ff;
   logic signed [VAL_W-1:0] pv_ff, a_ff, b_ff, rdata_ff;
   logic [RND_W-1:0]        lfsr_ff, lfsr_in;
   logic [PROD_W-1:0]       prod_ff;

   logic [CNT_W-1:0]        span_c, k_c;
   logic [IDX_W-1:0]        pick_c, rd_addr, wr_addr;
   logic                    rd_en, wr_en;
   logic signed [VAL_W-1:0] wr_data;

   assign span_c  = CNT_W'(hi_ff) - CNT_W'(lo_ff) + CNT_W'(1);
   assign k_c     = CNT_W'(st_ff) - CNT_W'(lo_ff) + CNT_W'(1);
   assign pick_c  = lo_ff + prod_ff[RND_W +: IDX_W];
   assign lfsr_in = lfsr_step(lfsr_ff);

   assign flags.err       = err_ff;
   assign flags.lo_ge_hi  = lo_ff >= hi_ff;
   assign flags.j_eq_hi   = j_ff == hi_ff;
   assign flags.gt_pv     = rdata_ff > pv_ff;
   assign flags.want_eq_k = want_ff == k_c;

   // read port
   always_comb begin
      rd_en   = !hold && (cw.rd != RD_NONE);
      rd_addr = lo_ff;
      unique case (cw.rd)
         RD_NONE: rd_addr = lo_ff;
         RD_PICK: rd_addr = pick_c;
         RD_HI:   rd_addr = hi_ff;
         RD_J:    rd_addr = j_ff;
         RD_ST:   rd_addr = st_ff;
         RD_LO:   rd_addr = lo_ff;
         default: rd_addr = lo_ff;
      endcase
   end

   // write port, shared by loading and partitioning
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load.addr;
      wr_data = load.data;
      if (load.we) begin
         wr_en = 1'b1;
      end else if (!hold) begin
         unique case (cw.wr)
            WR_NONE:    wr_en = 1'b0;
            WR_PICK_RD: begin
               wr_en   = 1'b1;
               wr_addr = pick_ff;
               wr_data = rdata_ff;
            end
            WR_HI_A: begin
               wr_en   = 1'b1;
               wr_addr = hi_ff;
               wr_data = a_ff;
            end
            WR_ST_A: begin
               wr_en   = 1'b1;
               wr_addr = st_ff;
               wr_data = a_ff;
            end
            WR_J_B: begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = b_ff;
            end
            WR_ST_PV: begin
               wr_en   = 1'b1;
               wr_addr = st_ff;
               wr_data = pv_ff;
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else if (!hold && cw.act == ACT_RAND) begin
         lfsr_ff <= lfsr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start.go) begin
         lo_ff   <= '0;
         hi_ff   <= IDX_W'(start.count - CNT_W'(1));
         want_ff <= CNT_W'(start.rank);
         err_ff  <= (start.rank == '0) || (32'(start.rank) > 32'(start.count));
      end else if (!hold) begin
         unique case (cw.act)
            ACT_RAND:    prod_ff <= PROD_W'(lfsr_in) * PROD_W'(span_c);
            ACT_PICK:    pick_ff <= pick_c;
            ACT_A:       a_ff    <= rdata_ff;
            ACT_PV_INIT: begin
               pv_ff <= a_ff;
               j_ff  <= lo_ff;
               st_ff <= lo_ff;
            end
            ACT_B:       b_ff    <= rdata_ff;
            ACT_ADV: begin
               st_ff <= st_ff + IDX_W'(1);
               j_ff  <= j_ff + IDX_W'(1);
            end
            ACT_JINC:    j_ff    <= j_ff + IDX_W'(1);
            ACT_NARROW: begin
               if (want_ff < k_c) begin
                  hi_ff <= st_ff - IDX_W'(1);
               end else begin
                  want_ff <= want_ff - k_c;
                  lo_ff   <= st_ff + IDX_W'(1);
               end
            end
            ACT_NONE, ACT_DONE_PV, ACT_DONE_RD, ACT_DONE_ERR: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res_value = '0;
      res_err   = 1'b0;
      unique case (cw.act)
         ACT_DONE_PV:  res_value = pv_ff;
         ACT_DONE_RD:  res_value = rdata_ff;
         ACT_DONE_ERR: res_err   = 1'b1;
         default:      res_value = '0;
      endcase
   end

endmodule

// ===== rtl/core/kth_smallest_select.sv =====
// top level of the rank selector: loading, sequencer, datapath and response register
//
// usage
//   req carries one signed 32-bit value per word; the word with last set
//   closes the set and its rank field names the wanted position, 1 being
//   the smallest. at most 64 values are kept, later ones are dropped.
//   rsp carries one word per closed set: the selected value, or zero with
//   rank_error set when rank is zero or above the number of kept values.
//   loading takes one word per cycle while req.ready is high. after the closing word req.ready
//   stays low while a microcoded quickselect runs over the element store,
//   which has a single read and a single write port. on an error the check
//   step jumps straight to the error step, which ends the selection. the
//   response sits in an output register; loading of the next set goes on
//   while it waits. if a new answer is ready while the previous one is
//   still not taken, the sequencer holds on its last step.
//   reset clears the count, the sequencer and the output valid flag and
//   reloads the pivot generator; the store needs no clearing.
module kth_smallest_select
   import kts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   kts_req_if.sink      req,
   kts_rsp_if.source    rsp
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_sel_ff;
   logic                    rsp_err_ff;

   logic                    req_fire, keep, stall, hold;
   logic [CNT_W-1:0]        count_next;
   load_type                load;
   start_type               start;
   uword_type               cw;
   flags_type               flags;
   seq_stat_type            stat;
   logic signed [VAL_W-1:0] res_value;
   logic                    res_err;

   assign req.ready  = !stat.busy;
   assign req_fire   = req.valid && req.ready;
   assign keep       = count_ff < CNT_W'(MAX_ELEMENTS);
   assign count_next = count_ff + CNT_W'(keep);

   assign load.we   = req_fire && keep;
   assign load.addr = count_ff[IDX_W-1:0];
   assign load.data = req.value;

   assign start.go    = req_fire && req.last;
   assign start.count = count_next;
   assign start.rank  = req.rank;

   assign stall = rsp_valid_ff && !rsp.ready;

   always_comb begin
      count_in = count_ff;
      if (req_fire) count_in = req.last ? '0 : count_next;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.finish) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.finish) begin
         rsp_sel_ff <= res_value;
         rsp_err_ff <= res_err;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.selected   = rsp_sel_ff;
   assign rsp.rank_error = rsp_err_ff;

   kts_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .start (start.go),
      .stall (stall),
      .flags (flags),
      .cw    (cw),
      .hold  (hold),
      .stat  (stat)
   );

   kts_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .start     (start),
      .cw        (cw),
      .hold      (hold),
      .flags     (flags),
      .res_value (res_value),
      .res_err   (res_err)
   );

   // closing word always starts the sequencer
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req.last |=> stat.busy)
      else $error("selection did not start after closing word");

   // fill count stays within the store
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond store depth");

   // an error answer carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_sel_ff == '0)
      else $error("error response with nonzero value");

   // end of selection leaves an answer in the output register
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(stat.busy) |-> rsp_valid_ff)
      else $error("selection ended without a response");

endmodule
